[sv/lkv_pkg.sv]
// shared types and constants of the lru key-value cache
// no dependencies; imported by lkv_cell, lkv_ctrl, lru_key_value_cache_top and the testbench
package lkv_pkg;

  localparam int KEY_W = 32;
  localparam int VAL_W = 32;
  localparam int CAP_W = 5;

  localparam logic [CAP_W-1:0] CAP_RESET  = 5'd16;
  localparam logic [VAL_W-1:0] MISS_VALUE = {VAL_W{1'b1}};
  localparam logic [VAL_W-1:0] PUT_VALUE  = {VAL_W{1'b0}};

  // operation codes
  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  // which cell an update command selects
  localparam logic [1:0] TGT_NONE = 2'd0;
  localparam logic [1:0] TGT_HIT  = 2'd1;
  localparam logic [1:0] TGT_FREE = 2'd2;
  localparam logic [1:0] TGT_LRU  = 2'd3;

  // lookup token passed from cell to cell
  typedef struct packed {
    logic             active;
    logic             hit;
    logic             free_taken;
    logic [VAL_W-1:0] value;
  } lkv_scan_t;

  // update command broadcast to every cell
  typedef struct packed {
    logic             upd;
    logic [1:0]       tgt;
    logic             wr_val;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } lkv_cmd_t;

endpackage

[sv/lru_key_value_cache_top.sv]
// top level of the fully associative lru key-value cache
// one transaction at a time: in_stall holds off a new one until the last has retired,
//   after its lookup token has passed through the row of DEPTH cells, one cell per cycle
// reset (synchronous, rst_n low): valid marks, ranks and occupancy cleared,
//   capacity set to 16; keys and values are left as they are
module lru_key_value_cache_top #(
  parameter int DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_operation,
  input  logic signed [lkv_pkg::KEY_W-1:0] in_lookup_key,
  input  logic signed [lkv_pkg::VAL_W-1:0] in_write_value,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_found,
  output logic signed [lkv_pkg::VAL_W-1:0] out_read_value,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [lkv_pkg::CAP_W-1:0]        cfg_capacity
);
  import lkv_pkg::*;

  localparam int RANK_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int OCC_W  = $clog2(DEPTH + 1);

  lkv_scan_t         scan_chain [DEPTH+1];
  logic [RANK_W-1:0] hrank_chain [DEPTH+1];
  lkv_cmd_t          cmd;
  logic [RANK_W-1:0] thresh;

  // sequencer
  lkv_ctrl #(
    .DEPTH  (DEPTH),
    .RANK_W (RANK_W),
    .OCC_W  (OCC_W)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_operation   (in_operation),
    .in_lookup_key  (in_lookup_key),
    .in_write_value (in_write_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_found      (out_found),
    .out_read_value (out_read_value),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_capacity   (cfg_capacity),
    .scan_head      (scan_chain[0]),
    .hrank_head     (hrank_chain[0]),
    .scan_tail      (scan_chain[DEPTH]),
    .hrank_tail     (hrank_chain[DEPTH]),
    .cmd            (cmd),
    .thresh         (thresh)
  );

  // row of entry cells, lookup token handed down one cell per cycle
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    lkv_cell #(
      .RANK_W (RANK_W)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .scan_in   (scan_chain[i]),
      .hrank_in  (hrank_chain[i]),
      .cmd       (cmd),
      .thresh    (thresh),
      .scan_out  (scan_chain[i+1]),
      .hrank_out (hrank_chain[i+1])
    );
  end

endmodule

[sv/lkv_cell.sv]
// one entry of the cache: valid mark, key, value and recency rank
// depends on lkv_pkg for the lookup token and update command types
module lkv_cell #(
  parameter int RANK_W = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  lkv_pkg::lkv_scan_t  scan_in,
  input  logic [RANK_W-1:0]   hrank_in,
  input  lkv_pkg::lkv_cmd_t   cmd,
  input  logic [RANK_W-1:0]   thresh,
  output lkv_pkg::lkv_scan_t  scan_out,
  output logic [RANK_W-1:0]   hrank_out
);
  import lkv_pkg::*;

  logic              valid_r, valid_nxt;
  logic [RANK_W-1:0] rank_r, rank_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic [VAL_W-1:0]  val_r, val_nxt;
  logic              hit_here_r, hit_here_nxt;
  logic              free_here_r, free_here_nxt;
  lkv_scan_t         scan_r, scan_nxt;
  logic [RANK_W-1:0] hrank_r, hrank_nxt;
  logic              match;
  logic              is_tgt;

  assign match = valid_r && (key_r == cmd.key);

  // update target selection
  always_comb begin
    case (cmd.tgt)
      TGT_HIT:  is_tgt = hit_here_r;
      TGT_FREE: is_tgt = free_here_r;
      TGT_LRU:  is_tgt = valid_r && (rank_r == thresh);
      default:  is_tgt = 1'b0;
    endcase
  end

  // lookup pass and entry update
  always_comb begin
    valid_nxt     = valid_r;
    rank_nxt      = rank_r;
    key_nxt       = key_r;
    val_nxt       = val_r;
    hit_here_nxt  = hit_here_r;
    free_here_nxt = free_here_r;
    scan_nxt      = scan_r;
    hrank_nxt     = hrank_r;
    scan_nxt.active = 1'b0;
    if (scan_in.active) begin
      scan_nxt.active     = 1'b1;
      scan_nxt.hit        = scan_in.hit | match;
      scan_nxt.free_taken = scan_in.free_taken | ~valid_r;
      scan_nxt.value      = match ? val_r : scan_in.value;
      hrank_nxt           = match ? rank_r : hrank_in;
      hit_here_nxt        = match;
      free_here_nxt       = ~valid_r & ~scan_in.free_taken;
    end
    if (cmd.upd) begin
      if (is_tgt) begin
        valid_nxt = 1'b1;
        rank_nxt  = '0;
        key_nxt   = cmd.key;
        if (cmd.wr_val) begin
          val_nxt = cmd.value;
        end
      end else if (valid_r && (rank_r < thresh)) begin
        rank_nxt = rank_r + RANK_W'(1);
      end
    end
  end

  // control state and lookup token
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r       <= 1'b0;
      rank_r        <= '0;
      hit_here_r    <= 1'b0;
      free_here_r   <= 1'b0;
      scan_r        <= '0;
    end else begin
      valid_r       <= valid_nxt;
      rank_r        <= rank_nxt;
      hit_here_r    <= hit_here_nxt;
      free_here_r   <= free_here_nxt;
      scan_r        <= scan_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    key_r               <= key_nxt;
    val_r               <= val_nxt;
    hrank_r             <= hrank_nxt;
  end

  assign scan_out  = scan_r;
  assign hrank_out = hrank_r;

endmodule

[sv/lkv_ctrl.sv]
// sequencer of the cache: transaction handshakes, capacity register, occupancy
// and the decision that turns a lookup summary into an update command; uses lkv_pkg
module lkv_ctrl #(
  parameter int DEPTH  = 16,
  parameter int RANK_W = 4,
  parameter int OCC_W  = 5
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_operation,
  input  logic signed [lkv_pkg::KEY_W-1:0] in_lookup_key,
  input  logic signed [lkv_pkg::VAL_W-1:0] in_write_value,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_found,
  output logic signed [lkv_pkg::VAL_W-1:0] out_read_value,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [lkv_pkg::CAP_W-1:0]        cfg_capacity,
  output lkv_pkg::lkv_scan_t               scan_head,
  output logic [RANK_W-1:0]                hrank_head,
  input  lkv_pkg::lkv_scan_t               scan_tail,
  input  logic [RANK_W-1:0]                hrank_tail,
  output lkv_pkg::lkv_cmd_t                cmd,
  output logic [RANK_W-1:0]                thresh
);
  import lkv_pkg::*;

  localparam int CMP_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_UPD  = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic             launch_r, launch_nxt;
  logic [CAP_W-1:0] cap_r, cap_nxt;
  logic [OCC_W-1:0] occ_r, occ_nxt;
  logic             op_r, op_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [VAL_W-1:0] wval_r, wval_nxt;
  logic             found_r, found_nxt;
  logic [VAL_W-1:0] hval_r, hval_nxt;
  logic [RANK_W-1:0] hrank_r, hrank_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_found_r, out_found_nxt;
  logic [VAL_W-1:0] out_value_r, out_value_nxt;
  logic             accept;
  logic             out_free;
  logic             retire;
  logic [CMP_W-1:0] eff_cap;
  logic             full;
  logic             do_upd;
  logic [1:0]       tgt;
  logic             wr_val;
  logic             grow;

  assign accept   = in_valid && (state_r == ST_IDLE);
  assign out_free = !out_valid_r || !out_stall;
  assign retire   = (state_r == ST_UPD) && out_free;

  // effective capacity is the smaller of the register and the depth
  assign eff_cap = (CMP_W'(cap_r) < CMP_W'(DEPTH)) ? CMP_W'(cap_r) : CMP_W'(DEPTH);
  assign full    = CMP_W'(occ_r) >= eff_cap;

  // update decision from the lookup summary
  always_comb begin
    do_upd = 1'b0;
    tgt    = TGT_NONE;
    wr_val = 1'b0;
    thresh = '0;
    grow   = 1'b0;
    if (found_r) begin
      do_upd = 1'b1;
      tgt    = TGT_HIT;
      wr_val = (op_r == OP_PUT);
      thresh = hrank_r;
    end else if (op_r == OP_PUT) begin
      wr_val = 1'b1;
      if (full) begin
        do_upd = (occ_r != '0);
        tgt    = TGT_LRU;
        thresh = RANK_W'(occ_r - OCC_W'(1));
      end else begin
        do_upd = 1'b1;
        tgt    = TGT_FREE;
        thresh = RANK_W'(occ_r);
        grow   = 1'b1;
      end
    end
  end

  assign cmd.upd    = retire && do_upd;
  assign cmd.tgt    = tgt;
  assign cmd.wr_val = wr_val;
  assign cmd.key    = key_r;
  assign cmd.value  = wval_r;

  // lookup token launched into the first cell
  assign scan_head.active     = launch_r;
  assign scan_head.hit        = 1'b0;
  assign scan_head.free_taken = 1'b0;
  assign scan_head.value      = '0;
  assign hrank_head           = '0;

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    launch_nxt    = 1'b0;
    cap_nxt       = cap_r;
    occ_nxt       = occ_r;
    op_nxt        = op_r;
    key_nxt       = key_r;
    wval_nxt      = wval_r;
    found_nxt     = found_r;
    hval_nxt      = hval_r;
    hrank_nxt     = hrank_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_found_nxt = out_found_r;
    out_value_nxt = out_value_r;
    if (cfg_valid && cfg_ready) begin
      cap_nxt = cfg_capacity;
    end
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          op_nxt     = in_operation;
          key_nxt    = $unsigned(in_lookup_key);
          wval_nxt   = $unsigned(in_write_value);
          launch_nxt = 1'b1;
          state_nxt  = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_tail.active) begin
          found_nxt = scan_tail.hit;
          hval_nxt  = scan_tail.value;
          hrank_nxt = hrank_tail;
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = found_r;
          if (op_r == OP_PUT) begin
            out_value_nxt = PUT_VALUE;
          end else begin
            out_value_nxt = found_r ? hval_r : MISS_VALUE;
          end
          if (grow) begin
            occ_nxt = occ_r + OCC_W'(1);
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      launch_r    <= 1'b0;
      cap_r       <= CAP_RESET;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      launch_r    <= launch_nxt;
      cap_r       <= cap_nxt;
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    key_r       <= key_nxt;
    wval_r      <= wval_nxt;
    found_r     <= found_nxt;
    hval_r      <= hval_nxt;
    hrank_r     <= hrank_nxt;
    out_found_r <= out_found_nxt;
    out_value_r <= out_value_nxt;
  end

  assign in_stall       = (state_r != ST_IDLE);
  assign cfg_ready      = (state_r == ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_found      = out_found_r;
  assign out_read_value = $signed(out_value_r);

  // checks
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CMP_W'(occ_r) <= CMP_W'(DEPTH))
    else $error("occupancy beyond depth");

  a_tail_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    scan_tail.active |-> (state_r == ST_SCAN))
    else $error("lookup token arrived outside a scan");

  a_accept_launch: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (launch_r && (state_r == ST_SCAN)))
    else $error("accepted transaction not launched");

  a_result_from_upd: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_UPD))
    else $error("result raised outside the update step");

  a_upd_only_retire: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.upd |-> (state_r == ST_UPD) && out_free)
    else $error("entry update outside the update step");

endmodule

[verif/tb_lru_key_value_cache_top.sv]
// testbench for lru_key_value_cache_top: directed and random get/put traffic
// checked against a shadow lru store in a scoreboard class
// depends on lkv_pkg and lru_key_value_cache_top
module tb_lru_key_value_cache_top;
  import lkv_pkg::*;

  localparam int DEPTH     = 16;
  localparam int POOL_SIZE = 24;
  localparam int PHASE_LEN = 55;

  typedef struct {
    logic             found;
    logic [VAL_W-1:0] value;
  } lookup_reply_t;

  // shadow copy of the cache contents and the replies it predicts
  class cache_scoreboard;
    logic [CAP_W-1:0] capacity;
    bit               line_valid[DEPTH];
    logic [KEY_W-1:0] line_key[DEPTH];
    logic [VAL_W-1:0] line_value[DEPTH];
    int unsigned      line_age[DEPTH];
    int unsigned      fill;
    lookup_reply_t    replies_due[$];
    int unsigned      mismatches;

    function new();
      capacity   = CAP_RESET;
      fill       = 0;
      mismatches = 0;
      for (int i = 0; i < DEPTH; i++) begin
        line_valid[i] = 1'b0;
        line_age[i]   = 0;
      end
    endfunction

    function void set_capacity(logic [CAP_W-1:0] c);
      capacity = c;
    endfunction

    // line s becomes most recent; lines more recent than it age by one
    function void promote(int s);
      int unsigned old_age;
      old_age = line_age[s];
      for (int i = 0; i < DEPTH; i++)
        if (line_valid[i] && i != s && line_age[i] < old_age) line_age[i]++;
      line_age[s] = 0;
    endfunction

    // predict the reply to one accepted transaction and update the shadow
    function void note_request(logic op, logic [KEY_W-1:0] key, logic [VAL_W-1:0] val);
      int            hit;
      int            victim;
      int unsigned   limit;
      lookup_reply_t r;
      hit    = -1;
      victim = -1;
      limit  = (capacity < DEPTH) ? capacity : DEPTH;
      for (int i = 0; i < DEPTH; i++)
        if (hit < 0 && line_valid[i] && line_key[i] == key) hit = i;

      if (op == OP_GET) begin
        r.found = (hit >= 0);
        r.value = MISS_VALUE;
        if (hit >= 0) begin
          r.value = line_value[hit];
          promote(hit);
        end
      end else begin
        r.found = (hit >= 0);
        r.value = PUT_VALUE;
        if (hit >= 0) begin
          line_value[hit] = val;
          promote(hit);
        end else if (fill >= limit) begin
          // full at the current capacity: replace the least recent line
          for (int i = 0; i < DEPTH; i++)
            if (line_valid[i] && (victim < 0 || line_age[i] > line_age[victim])) victim = i;
          if (victim >= 0) begin
            line_key[victim]   = key;
            line_value[victim] = val;
            promote(victim);
          end
        end else begin
          // lowest free line takes the key, every valid line ages
          for (int i = 0; i < DEPTH; i++)
            if (victim < 0 && !line_valid[i]) victim = i;
          if (victim >= 0) begin
            for (int i = 0; i < DEPTH; i++)
              if (line_valid[i]) line_age[i]++;
            line_valid[victim] = 1'b1;
            line_key[victim]   = key;
            line_value[victim] = val;
            line_age[victim]   = 0;
            fill++;
          end
        end
      end
      replies_due.push_back(r);
    endfunction

    // compare one accepted reply with the oldest prediction
    function void check_reply(logic found, logic [VAL_W-1:0] value);
      lookup_reply_t r;
      if (replies_due.size() == 0) begin
        $error("unexpected reply: found=%0b read_value=%h", found, value);
        mismatches++;
      end else begin
        r = replies_due.pop_front();
        if (found !== r.found) begin
          $error("found: expected %0b, actual %0b", r.found, found);
          mismatches++;
        end
        if (value !== r.value) begin
          $error("read_value: expected %h, actual %h", r.value, value);
          mismatches++;
        end
      end
    endfunction

    function int unsigned outstanding();
      return replies_due.size();
    endfunction
  endclass

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  logic                    in_operation;
  logic signed [KEY_W-1:0] in_lookup_key;
  logic signed [VAL_W-1:0] in_write_value;
  logic                    out_valid;
  logic                    out_stall;
  logic                    out_found;
  logic signed [VAL_W-1:0] out_read_value;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CAP_W-1:0]        cfg_capacity;

  cache_scoreboard         sb = new();
  logic [KEY_W-1:0]        key_pool[POOL_SIZE];
  bit                      no_idle;

  lru_key_value_cache_top #(.DEPTH(DEPTH)) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_operation   (in_operation),
    .in_lookup_key  (in_lookup_key),
    .in_write_value (in_write_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_found      (out_found),
    .out_read_value (out_read_value),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_capacity   (cfg_capacity)
  );

  // clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // result side: random stall before each result
  initial begin
    int unsigned hold;
    out_stall <= 1'b0;
    forever begin
      hold = no_idle ? 0 : $urandom_range(0, 19);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // reply monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_reply(out_found, out_read_value);
  end

  // one get or put transaction, with a random gap ahead of it
  task automatic issue_request(logic op, logic [KEY_W-1:0] key, logic [VAL_W-1:0] val);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_operation   <= op;
    in_lookup_key  <= key;
    in_write_value <= val;
    do @(posedge clk); while (in_stall);
    sb.note_request(op, key, val);
  endtask

  task automatic wait_drained();
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // capacity write, only with the cache idle
  task automatic write_capacity(logic [CAP_W-1:0] c);
    in_valid <= 1'b0;
    wait_drained();
    cfg_valid    <= 1'b1;
    cfg_capacity <= c;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_capacity(c);
  endtask

  function automatic logic [KEY_W-1:0] pick_key(int unsigned span);
    if ($urandom_range(0, 99) < 12) return $urandom;
    return key_pool[$urandom_range(0, span - 1)];
  endfunction

  initial begin
    logic [CAP_W-1:0] phase_cap[10];
    int unsigned      span;
    int unsigned      wait_cycles;
    phase_cap = '{5'd16, 5'd2, 5'd17, 5'd0, 5'd5, 5'd31, 5'd1, 5'd9, 5'd16, 5'd3};
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7fff_ffff;
    key_pool[2] = 32'h0000_0000;
    key_pool[3] = 32'hffff_ffff;
    for (int i = 4; i < POOL_SIZE; i++) key_pool[i] = $urandom;
    no_idle        = 1'b0;
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_operation   <= OP_GET;
    in_lookup_key  <= '0;
    in_write_value <= '0;
    cfg_valid      <= 1'b0;
    cfg_capacity   <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // capacity zero on an empty store keeps nothing
    write_capacity(5'd0);
    issue_request(OP_GET, key_pool[0], 32'h0);
    issue_request(OP_PUT, key_pool[0], 32'h1234_5678);
    issue_request(OP_GET, key_pool[0], 32'h0);
    issue_request(OP_GET, key_pool[1], 32'hdead_beef);

    // capacity one: second key evicts the first
    write_capacity(5'd1);
    issue_request(OP_PUT, key_pool[0], 32'h7fff_ffff);
    issue_request(OP_PUT, key_pool[1], 32'h8000_0000);
    issue_request(OP_GET, key_pool[0], 32'h0);
    issue_request(OP_GET, key_pool[1], 32'h0);
    issue_request(OP_PUT, key_pool[1], 32'hffff_ffff);
    issue_request(OP_GET, key_pool[1], 32'h5555_aaaa);

    // capacity above the depth, extreme keys and values
    write_capacity(5'd31);
    issue_request(OP_PUT, key_pool[0], 32'h8000_0000);
    issue_request(OP_PUT, key_pool[2], 32'h0000_0000);
    issue_request(OP_PUT, key_pool[3], 32'hffff_ffff);
    issue_request(OP_GET, key_pool[0], 32'h0);
    issue_request(OP_GET, key_pool[1], 32'h0);
    issue_request(OP_GET, key_pool[2], 32'hffff_ffff);
    issue_request(OP_GET, key_pool[3], 32'h0);
    issue_request(OP_PUT, key_pool[2], 32'h7fff_ffff);
    issue_request(OP_GET, key_pool[2], 32'h0);

    // random phases over a range of capacities, some without idling
    foreach (phase_cap[p]) begin
      write_capacity(phase_cap[p]);
      no_idle = (p == 3 || p == 7);
      span    = (phase_cap[p] + 4 < POOL_SIZE) ? phase_cap[p] + 4 : POOL_SIZE;
      for (int n = 0; n < PHASE_LEN; n++)
        issue_request(($urandom_range(0, 99) < 60) ? OP_PUT : OP_GET, pick_key(span), $urandom);
    end
    no_idle = 1'b0;
    in_valid <= 1'b0;

    // drain, then let the pipeline settle
    for (wait_cycles = 0; sb.outstanding() != 0 && wait_cycles < 5000; wait_cycles++)
      @(posedge clk);
    repeat (DEPTH + 4) @(posedge clk);
    if (sb.outstanding() != 0) $error("%0d replies never arrived", sb.outstanding());
    if (sb.mismatches == 0 && sb.outstanding() == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  // watchdog
  initial begin
    #4_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
